@@ sv/mstt_pkg.sv @@
// shared types, codes and sizes for the timeout slot table
package mstt_pkg;

	localparam int SLOTS     = 16;
	localparam int SLOT_W    = $clog2(SLOTS);
	localparam int TIME_W    = 32;
	localparam int QUANTUM_W = 16;
	localparam int DIV_CNT_W = $clog2(TIME_W);

	localparam logic [SLOT_W:0]      SLOT_CNT      = (SLOT_W + 1)'(SLOTS);
	localparam logic [QUANTUM_W-1:0] QUANTUM_RESET = QUANTUM_W'(10);

	// input mode codes
	localparam logic [1:0] MODE_CREATE = 2'd0;
	localparam logic [1:0] MODE_STOP   = 2'd1;
	localparam logic [1:0] MODE_TICK   = 2'd2;

	// result event codes
	localparam logic [1:0] EV_CREATED = 2'd0;
	localparam logic [1:0] EV_FULL    = 2'd1;
	localparam logic [1:0] EV_EXPIRED = 2'd2;

	typedef struct packed {
		logic [1:0]        mode;
		logic [TIME_W-1:0] timeout_ms;
		logic              notify_by_flag;
		logic [3:0]        slot;
	} req_item_t;

	typedef struct packed {
		logic [1:0] event_res;
		logic [3:0] slot_id;
		logic       flag_kind;
		logic       last;
	} rsp_item_t;

	// one memory word per slot
	typedef struct packed {
		logic              kind;
		logic [TIME_W-1:0] rem;
	} slot_word_t;

endpackage

@@ sv/multi_slot_timeout_table.sv @@
// timeout slot table: create, stop and tick over a memory of slot timers
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+------------------------------
//  req     | in        | req_valid/req_stall | mode, timeout_ms, flag, slot
//  rsp     | out       | rsp_valid/rsp_stall | event, slot_id, kind, last
//  cfg     | in        | cfg_we              | cfg_wdata = quantum_ms
//
// stop clears the armed bit on accept; create runs accept, 32 remainder steps
// of the bit-serial mod unit and one write; a full table skips the remainder steps
// tick walks the slot memory one slot per cycle unless a pending expiry waits on
// the output register (accept, 16 reads, the decision on the last slot, one closing
// step), set by the single read port of the slot memory
// reset clears the armed bits and control state; memory words are only used
// for armed slots, so the memory needs no clearing pass
// rsp_stall holds a walk only when an expiry must leave while the output
// register is still occupied; req is stalled whenever an item is busy
module multi_slot_timeout_table (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            req_valid,
	output logic                            req_stall,
	input  mstt_pkg::req_item_t             req,
	output logic                            rsp_valid,
	input  logic                            rsp_stall,
	output mstt_pkg::rsp_item_t             rsp,
	input  logic                            cfg_we,
	input  logic [mstt_pkg::QUANTUM_W-1:0]  cfg_wdata
);
	import mstt_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_DIV  = 4'b0010,
		ST_CRT  = 4'b0100,
		ST_WALK = 4'b1000
	} state_t;

	// lowest clear bit of the armed vector
	function automatic logic [SLOT_W-1:0] first_free(input logic [SLOTS-1:0] free);
		logic [SLOT_W-1:0] idx;
		idx = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (free[i]) idx = SLOT_W'(i);
		end
		return idx;
	endfunction

	state_t                state_q;
	logic [QUANTUM_W-1:0]  quantum_q;
	logic [QUANTUM_W-1:0]  q_eff;
	logic [SLOTS-1:0]      armed_q;

	// create context
	logic [SLOT_W-1:0]     slot_q;
	logic                  kind_q;
	logic                  full_q;
	logic [TIME_W-1:0]     t_q;
	logic [TIME_W-1:0]     dsh_q;
	logic [QUANTUM_W-1:0]  rem_q;
	logic [DIV_CNT_W-1:0]  div_cnt_q;
	logic [QUANTUM_W:0]    div_cand;
	logic [QUANTUM_W-1:0]  div_next;

	// tick walk pipeline
	logic [SLOT_W:0]       rd_idx_q;
	logic                  ev_valid_s1;
	logic [SLOT_W-1:0]     ev_idx_s1;
	slot_word_t            rd_data_s1;
	logic                  pend_valid_q;
	logic [SLOT_W-1:0]     pend_slot_q;
	logic                  pend_kind_q;

	// slot memory
	slot_word_t            mem [SLOTS];
	logic                  mem_we;
	logic [SLOT_W-1:0]     mem_waddr;
	slot_word_t            mem_wdata;
	logic                  mem_re;

	// output register
	logic                  out_valid_q;
	rsp_item_t             out_q;
	logic                  out_free;
	logic                  out_load;
	rsp_item_t             out_next;

	logic                  acc;
	logic                  ev_armed;
	logic                  ev_exp;
	logic                  ev_dec;
	logic                  walk_end;
	logic                  need_out;
	logic                  advance;
	logic                  rd_more;
	logic                  crt_fire;

	assign req_stall = (state_q != ST_IDLE);
	assign acc       = req_valid && !req_stall;
	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;
	assign out_free  = !out_valid_q || !rsp_stall;

	// a zero quantum behaves as one millisecond
	assign q_eff = (quantum_q == '0) ? QUANTUM_W'(1) : quantum_q;

	// one restoring remainder step per cycle, dividend msb first
	assign div_cand = {rem_q, dsh_q[TIME_W-1]};
	always_comb begin
		if (div_cand >= {1'b0, q_eff}) begin
			div_next = QUANTUM_W'(div_cand - {1'b0, q_eff});
		end else begin
			div_next = div_cand[QUANTUM_W-1:0];
		end
	end

	// walk stage: decide on the slot whose word came back this cycle
	assign ev_armed = ev_valid_s1 && armed_q[ev_idx_s1];
	assign ev_exp   = ev_armed && (rd_data_s1.rem < {{(TIME_W-QUANTUM_W){1'b0}}, q_eff});
	assign ev_dec   = ev_armed && !ev_exp;
	assign walk_end = (rd_idx_q == SLOT_CNT) && !ev_valid_s1;
	assign rd_more  = (rd_idx_q != SLOT_CNT);
	// an earlier expiry must leave before a new one can be held back
	assign need_out = pend_valid_q && (ev_exp || walk_end);
	assign advance  = (state_q == ST_WALK) && (!need_out || out_free);
	assign crt_fire = (state_q == ST_CRT) && out_free;

	// memory access control
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = ev_idx_s1;
		mem_wdata = '{kind: rd_data_s1.kind, rem: rd_data_s1.rem - TIME_W'(q_eff)};
		mem_re    = advance && rd_more;
		if (crt_fire && !full_q) begin
			mem_we    = 1'b1;
			mem_waddr = slot_q;
			mem_wdata = '{kind: kind_q, rem: t_q - TIME_W'(rem_q)};
		end else if (advance && ev_dec) begin
			mem_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= mem_wdata;
		if (mem_re) rd_data_s1 <= mem[rd_idx_q[SLOT_W-1:0]];
	end

	// result selection for the output register
	always_comb begin
		out_load = 1'b0;
		out_next = out_q;
		if (crt_fire) begin
			out_load = 1'b1;
			out_next = '{event_res: full_q ? EV_FULL : EV_CREATED,
			             slot_id:   full_q ? 4'd0 : 4'(slot_q),
			             flag_kind: 1'b0,
			             last:      1'b1};
		end else if (advance && need_out) begin
			out_load = 1'b1;
			out_next = '{event_res: EV_EXPIRED,
			             slot_id:   4'(pend_slot_q),
			             flag_kind: pend_kind_q,
			             last:      walk_end};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) out_q <= out_next;
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quantum_q <= QUANTUM_RESET;
		end else if (cfg_we) begin
			quantum_q <= cfg_wdata;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			armed_q      <= '0;
			div_cnt_q    <= '0;
			rd_idx_q     <= '0;
			ev_valid_s1  <= 1'b0;
			pend_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (acc) begin
						case (req.mode)
							MODE_CREATE: begin
								div_cnt_q <= DIV_CNT_W'(TIME_W - 1);
								state_q   <= (&armed_q) ? ST_CRT : ST_DIV;
							end
							MODE_STOP: begin
								armed_q[req.slot[SLOT_W-1:0]] <= 1'b0;
							end
							MODE_TICK: begin
								rd_idx_q     <= '0;
								ev_valid_s1  <= 1'b0;
								pend_valid_q <= 1'b0;
								state_q      <= ST_WALK;
							end
							default: begin
							end
						endcase
					end
				end
				ST_DIV: begin
					div_cnt_q <= div_cnt_q - DIV_CNT_W'(1);
					if (div_cnt_q == '0) state_q <= ST_CRT;
				end
				ST_CRT: begin
					if (out_free) begin
						if (!full_q) armed_q[slot_q] <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				ST_WALK: begin
					if (advance) begin
						if (rd_more) begin
							ev_valid_s1 <= 1'b1;
							rd_idx_q    <= rd_idx_q + (SLOT_W + 1)'(1);
						end else begin
							ev_valid_s1 <= 1'b0;
						end
						if (ev_exp) begin
							armed_q[ev_idx_s1] <= 1'b0;
							pend_valid_q       <= 1'b1;
						end
						if (walk_end) begin
							pend_valid_q <= 1'b0;
							state_q      <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers of the create and walk paths
	always_ff @(posedge clk) begin
		if (acc && req.mode == MODE_CREATE) begin
			slot_q <= first_free(~armed_q);
			full_q <= &armed_q;
			kind_q <= req.notify_by_flag;
			t_q    <= req.timeout_ms;
			dsh_q  <= req.timeout_ms;
			rem_q  <= '0;
		end else if (state_q == ST_DIV) begin
			dsh_q <= {dsh_q[TIME_W-2:0], 1'b0};
			rem_q <= div_next;
		end
		if (advance && rd_more) ev_idx_s1 <= rd_idx_q[SLOT_W-1:0];
		if (advance && ev_exp) begin
			pend_slot_q <= ev_idx_s1;
			pend_kind_q <= rd_data_s1.kind;
		end
	end

`ifndef ASSERT_OFF
	// the running remainder never reaches the quantum
	a_div_rem_below_q: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (rem_q < q_eff))
		else $error("remainder reached the quantum");

	// a held-back expiry exists only during a walk
	a_pend_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		pend_valid_q |-> (state_q == ST_WALK))
		else $error("pending expiry outside a walk");

	// a successful create leaves its slot armed
	a_create_arms: assert property (@(posedge clk) disable iff (!arst_n)
		(crt_fire && !full_q) |=> armed_q[$past(slot_q)])
		else $error("created slot not armed");

	// the walk index never passes the slot count
	a_walk_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK) |-> (rd_idx_q <= SLOT_CNT))
		else $error("walk index out of range");
`endif

endmodule
